FILE: hdl/sm4ke_pkg.sv
// shared types, constants and helper functions of the sm4 key expansion core
// no dependencies; imported by every module under hdl
`default_nettype none

package sm4ke_pkg;

    localparam int SM4KE_ROUNDS   = 32;
    localparam int ROUND_W        = 5;
    localparam int QUEUE_DEPTH    = 2;
    localparam int KEY_W          = 128;
    localparam int OUT_DATA_W     = 40;

    localparam logic [31:0] FK0 = 32'ha3b1bac6;
    localparam logic [31:0] FK1 = 32'h56aa3350;
    localparam logic [31:0] FK2 = 32'h677d9197;
    localparam logic [31:0] FK3 = 32'hb27022dc;

    typedef struct packed {
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
    } key_words_t;

    typedef struct packed {
        logic       valid;
        key_words_t words;
    } key_push_t;

    localparam logic [7:0] SM4_SBOX [0:255] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    // round constant: byte j of round i is ((4*i + j) * 7) mod 256, msb first
    function automatic logic [31:0] ck_word(input logic [ROUND_W-1:0] idx);
        logic [31:0] c;
        logic [7:0]  base;
        logic [7:0]  b;
        c    = '0;
        base = {1'b0, idx, 2'b00};
        for (int j = 0; j < 4; j++)
        begin
            b = 8'((base + 8'(j)) * 8'd7);
            c = {c[23:0], b};
        end
        return c;
    endfunction

    // byte-wise s-box followed by l'(t) = t ^ rotl13 ^ rotl23
    function automatic logic [31:0] sched_mix(input logic [31:0] v);
        logic [31:0] t;
        t = {SM4_SBOX[v[31:24]], SM4_SBOX[v[23:16]], SM4_SBOX[v[15:8]], SM4_SBOX[v[7:0]]};
        return t ^ {t[18:0], t[31:19]} ^ {t[8:0], t[31:9]};
    endfunction

endpackage

`default_nettype wire

FILE: hdl/sm4ke_front.sv
// input stage: takes a key transaction, applies the fk whitening and offers it to the queue
// depends on sm4ke_pkg
`default_nettype none

module sm4ke_front
    import sm4ke_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [63:0]      key_high,
    input  wire logic [63:0]      key_low,
    output key_push_t             push,
    input  wire logic             push_ready
);

    logic       front_valid_reg;
    logic       front_valid_next;
    key_words_t front_words_reg;
    logic       take;

    assign in_ready = !front_valid_reg || push_ready;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        front_valid_next = front_valid_reg;
        if (take)
        begin
            front_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            front_words_reg.w0 <= key_high[63:32] ^ FK0;
            front_words_reg.w1 <= key_high[31:0]  ^ FK1;
            front_words_reg.w2 <= key_low[63:32]  ^ FK2;
            front_words_reg.w3 <= key_low[31:0]   ^ FK3;
        end
    end

    assign push.valid = front_valid_reg;
    assign push.words = front_words_reg;

endmodule

`default_nettype wire

FILE: hdl/sm4ke_queue.sv
// short fifo of whitened keys between the input stage and the round engine
// depends on sm4ke_pkg
`default_nettype none

module sm4ke_queue
    import sm4ke_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire key_push_t push,
    output logic           push_ready,
    output key_push_t      head,
    input  wire logic      pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    key_words_t         slots [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop && (count_reg != '0);

    assign head.valid = count_reg != '0;
    assign head.words = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push.words;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/sm4ke_round_engine.sv
// round engine: one key schedule round per cycle while the output is not stalled, into a registered output stage
// depends on sm4ke_pkg
`default_nettype none

module sm4ke_round_engine
    import sm4ke_pkg::*;
#(
    parameter int ROUND_COUNT = SM4KE_ROUNDS
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire key_push_t          head,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [31:0]             round_key,
    output logic [ROUND_W-1:0]      round_number,
    output logic                    last_key
);

    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUND_COUNT - 1);

    logic                busy_reg;
    logic                busy_next;
    logic [ROUND_W-1:0]  round_reg;
    logic [ROUND_W-1:0]  round_next;
    key_words_t          words_reg;
    key_words_t          words_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [31:0]         round_key_reg;
    logic [ROUND_W-1:0]  round_number_reg;
    logic                last_key_reg;

    logic                advance;
    logic                is_last;
    logic                load;
    logic [31:0]         new_word;

    assign advance  = busy_reg && (!out_valid_reg || out_ready);
    assign is_last  = round_reg == LAST_ROUND;
    // next key may be loaded in the cycle the final round leaves
    assign load     = head.valid && (!busy_reg || (advance && is_last));
    assign pop      = load;
    assign new_word = words_reg.w0 ^ sched_mix(words_reg.w1 ^ words_reg.w2 ^ words_reg.w3
                                               ^ ck_word(round_reg));

    always_comb
    begin
        busy_next      = busy_reg;
        round_next     = round_reg;
        words_next     = words_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
            round_next     = round_reg + 1'b1;
            // sliding window of the last four words
            words_next     = '{w0: words_reg.w1, w1: words_reg.w2,
                               w2: words_reg.w3, w3: new_word};
            if (is_last)
            begin
                busy_next = 1'b0;
            end
        end
        if (load)
        begin
            busy_next  = 1'b1;
            round_next = '0;
            words_next = head.words;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        words_reg <= words_next;
        if (advance)
        begin
            round_key_reg    <= new_word;
            round_number_reg <= round_reg;
            last_key_reg     <= is_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign round_key    = round_key_reg;
    assign round_number = round_number_reg;
    assign last_key     = last_key_reg;

endmodule

`default_nettype wire

FILE: hdl/sm4ke_core_top_dummy_placeholder.sv
// round key ordering checks are carried at the end of the top level
// depends on sm4ke_pkg
`default_nettype none

module sm4ke_out_order
    import sm4ke_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               take,
    input  wire logic [ROUND_W-1:0] round_number,
    output logic [ROUND_W-1:0]      expected
);

    logic [ROUND_W-1:0] expected_reg;

    // tracks the round index the next delivered key should carry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg <= '0;
        end
        else if (take)
        begin
            expected_reg <= round_number + 1'b1;
        end
    end

    assign expected = expected_reg;

endmodule

`default_nettype wire

FILE: hdl/sm4_key_expansion_core.sv
// top level of the sm4 key expansion core: input stage, key queue and round engine
// depends on sm4ke_pkg, sm4ke_front, sm4ke_queue, sm4ke_round_engine, sm4ke_out_order
//
//  channel   direction  handshake             payload
//  s_axis    in         tvalid/tready         tdata: key_high, key_low (128 bits)
//  m_axis    out        tvalid/tready/tlast   tdata: round_key, round_number; tlast: last_key
//
// each key yields ROUND_COUNT round keys, one per cycle from the round engine while m_axis is not stalled
// keys follow through the engine with no gap when the next key waits in the queue
// the first round key passes the input stage register, a queue slot, the engine word registers and its output register
// a stall on m_axis holds the engine; two keys wait in the queue, one in the input stage
// reset clears all control state and discards keys in flight
`default_nettype none

module sm4_key_expansion_core
    import sm4ke_pkg::*;
#(
    parameter int ROUND_COUNT = SM4KE_ROUNDS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [KEY_W-1:0]      s_axis_tdata,   // key_high[63:0], key_low[127:64]
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // round_key[31:0], round_number[36:32], zero
    output logic                       m_axis_tlast
);

    key_push_t          push;
    logic               push_ready;
    key_push_t          head;
    logic               pop;
    logic [31:0]        round_key;
    logic [ROUND_W-1:0] round_number;
    logic               last_key;
    logic [ROUND_W-1:0] expected;

    sm4ke_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .key_high   (s_axis_tdata[63:0]),
        .key_low    (s_axis_tdata[127:64]),
        .push       (push),
        .push_ready (push_ready)
    );

    sm4ke_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .head       (head),
        .pop        (pop)
    );

    sm4ke_round_engine #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .round_key    (round_key),
        .round_number (round_number),
        .last_key     (last_key)
    );

    sm4ke_out_order u_order (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (m_axis_tvalid && m_axis_tready),
        .round_number (round_number),
        .expected     (expected)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - 32 - ROUND_W){1'b0}}, round_number, round_key};
    assign m_axis_tlast = last_key;

`ifndef SYNTHESIS
    a_last_round : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> round_number == ROUND_W'(ROUND_COUNT - 1))
        else $error("last flag on a round other than the final one");

    a_round_sequence : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (round_number == expected)
                          || (round_number == '0 && expected == ROUND_W'(ROUND_COUNT)))
        else $error("round keys out of order");

    a_queue_push : assert property (@(posedge clk) disable iff (!rst_n)
        push.valid && !push_ready |=> push.valid && $stable(push.words))
        else $error("held key lost between input stage and queue");
`endif

endmodule

`default_nettype wire
